>>> design/tsbi_pkg.sv
package tsbi_pkg;

  localparam int TablePoints = 16;
  localparam int IdxW        = $clog2(TablePoints);
  localparam int CntW        = $clog2(TablePoints + 1);
  localparam int FracBits    = 16;
  localparam int FracW       = FracBits + 1;
  localparam int KeyW        = 24;
  localparam int DayW        = 16;
  localparam int FuncW       = 2;
  localparam int StatusW     = 2;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 24;
  localparam int RemW        = KeyW + 1;
  localparam int ProdW       = KeyW + FracW;
  localparam int DivCntW     = $clog2(FracBits + 1);

  localparam logic [FracW-1:0] One = FracW'(1) << FracBits;

  localparam logic [CntW-1:0] DecayPointsRst = CntW'(6);
  localparam logic [CntW-1:0] MortPointsRst  = CntW'(0);

  localparam logic [KeyW-1:0] DecayKeyInit [TablePoints] = '{
    0: KeyW'(1), 1: KeyW'(3), 2: KeyW'(6), 3: KeyW'(13), 4: KeyW'(20), 5: KeyW'(42),
    default: '0
  };

  // 1.0, 0.16, 0.26, 0.13, 0.01, 0.003 rounded to nearest
  localparam logic [FracW-1:0] DecayFracInit [TablePoints] = '{
    0: FracW'(65536), 1: FracW'(10486), 2: FracW'(17039), 3: FracW'(8520),
    4: FracW'(655), 5: FracW'(197),
    default: '0
  };

  typedef enum logic [FuncW-1:0] {
    FUNC_QUERY    = 2'd0,
    FUNC_WR_DECAY = 2'd1,
    FUNC_WR_MORT  = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_MISS  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INITIAL_SPORES   = 2'd0,
    CFG_DECAY_POINTS     = 2'd1,
    CFG_MORTALITY_POINTS = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    TBL_DECAY = 1'b0,
    TBL_MORT  = 1'b1
  } tbl_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_ADJ,
    S_NEXT,
    S_LIVE,
    S_SAT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             en;
    tbl_sel_e         sel;
    logic [IdxW-1:0]  idx;
    logic [KeyW-1:0]  key;
    logic [FracW-1:0] frac;
  } tbl_wr_t;

  typedef struct packed {
    tbl_sel_e        sel;
    logic [IdxW-1:0] idx;
  } tbl_rd_t;

  typedef struct packed {
    logic [KeyW-1:0] initial_spores;
    logic [CntW-1:0] decay_n;
    logic [CntW-1:0] mort_n;
  } cfg_t;

  function automatic logic [CntW-1:0] clamp_count(input logic [CntW-1:0] c);
    logic [CntW-1:0] lim;
    lim = CntW'(TablePoints);
    return (c > lim) ? lim : c;
  endfunction

endpackage

>>> design/tsbi_in_if.sv
interface tsbi_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsbi_pkg::FuncW-1:0]    func;
  logic [tsbi_pkg::DayW-1:0]     day;
  logic [tsbi_pkg::IdxW-1:0]     point_index;
  logic [tsbi_pkg::KeyW-1:0]     point_key;
  logic [tsbi_pkg::FracW-1:0]    point_fraction;

  modport source (
    output valid, func, day, point_index, point_key, point_fraction,
    input  ready
  );

  modport sink (
    input  valid, func, day, point_index, point_key, point_fraction,
    output ready
  );
endinterface

>>> design/tsbi_out_if.sv
interface tsbi_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsbi_pkg::FracW-1:0]    mortality_rate;
  logic [tsbi_pkg::KeyW-1:0]     live_spores;
  logic [tsbi_pkg::StatusW-1:0]  status;

  modport source (
    output valid, mortality_rate, live_spores, status,
    input  ready
  );

  modport sink (
    input  valid, mortality_rate, live_spores, status,
    output ready
  );
endinterface

>>> design/two_stage_breakpoint_interpolator_top.sv
// Query: the time from input transfer to output valid is set by the point-by-point
// table scan, the 17-step shared divider per table and output back-pressure. Table
// writes complete in the transfer cycle. One item at a time; the input is not ready
// until the result is placed in the output register. Reset loads the default decay
// curve, clears the mortality table, spore count and mortality point count, and
// sets six decay points.
module two_stage_breakpoint_interpolator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tsbi_in_if.sink                         in_i,
  tsbi_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [tsbi_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tsbi_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [tsbi_pkg::KeyW-1:0] spores_q;
  logic [tsbi_pkg::CntW-1:0] dpts_q;
  logic [tsbi_pkg::CntW-1:0] mpts_q;
  logic [tsbi_pkg::CntW-1:0] dpts_clamped;

  tsbi_pkg::cfg_t    cfg;
  tsbi_pkg::tbl_wr_t tbl_wr;
  tsbi_pkg::tbl_rd_t tbl_rd;
  logic [tsbi_pkg::KeyW-1:0]  rd_key;
  logic [tsbi_pkg::FracW-1:0] rd_frac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spores_q <= '0;
      dpts_q   <= tsbi_pkg::DecayPointsRst;
      mpts_q   <= tsbi_pkg::MortPointsRst;
    end else if (cfg_we_i) begin
      unique case (tsbi_pkg::cfg_reg_e'(cfg_idx_i))
        tsbi_pkg::CFG_INITIAL_SPORES:   spores_q <= cfg_data_i[tsbi_pkg::KeyW-1:0];
        tsbi_pkg::CFG_DECAY_POINTS:     dpts_q   <= cfg_data_i[tsbi_pkg::CntW-1:0];
        tsbi_pkg::CFG_MORTALITY_POINTS: mpts_q   <= cfg_data_i[tsbi_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // decay table always has at least one point
  assign dpts_clamped       = tsbi_pkg::clamp_count(dpts_q);
  assign cfg.initial_spores = spores_q;
  assign cfg.decay_n        = (dpts_clamped == '0) ? tsbi_pkg::CntW'(1) : dpts_clamped;
  assign cfg.mort_n         = tsbi_pkg::clamp_count(mpts_q);

  tsbi_tables u_tables (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_i      (tbl_rd),
    .rd_key_o  (rd_key),
    .rd_frac_o (rd_frac)
  );

  tsbi_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .wr_o      (tbl_wr),
    .rd_o      (tbl_rd),
    .rd_key_i  (rd_key),
    .rd_frac_i (rd_frac)
  );

endmodule

>>> design/tsbi_tables.sv
module tsbi_tables (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tsbi_pkg::tbl_wr_t               wr_i,
  input  tsbi_pkg::tbl_rd_t               rd_i,
  output logic [tsbi_pkg::KeyW-1:0]       rd_key_o,
  output logic [tsbi_pkg::FracW-1:0]      rd_frac_o
);

  logic [tsbi_pkg::KeyW-1:0]  dkey_q  [tsbi_pkg::TablePoints];
  logic [tsbi_pkg::FracW-1:0] dfrac_q [tsbi_pkg::TablePoints];
  logic [tsbi_pkg::KeyW-1:0]  mkey_q  [tsbi_pkg::TablePoints];
  logic [tsbi_pkg::FracW-1:0] mfrac_q [tsbi_pkg::TablePoints];
  logic [tsbi_pkg::FracW-1:0] wr_frac;

  // fractions above 1.0 saturate
  assign wr_frac = (wr_i.frac > tsbi_pkg::One) ? tsbi_pkg::One : wr_i.frac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsbi_pkg::TablePoints; i++) begin
        dkey_q[i]  <= tsbi_pkg::DecayKeyInit[i];
        dfrac_q[i] <= tsbi_pkg::DecayFracInit[i];
        mkey_q[i]  <= '0;
        mfrac_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      if (wr_i.sel == tsbi_pkg::TBL_MORT) begin
        mkey_q[wr_i.idx]  <= wr_i.key;
        mfrac_q[wr_i.idx] <= wr_frac;
      end else begin
        dkey_q[wr_i.idx]  <= wr_i.key;
        dfrac_q[wr_i.idx] <= wr_frac;
      end
    end
  end

  always_comb begin
    if (rd_i.sel == tsbi_pkg::TBL_MORT) begin
      rd_key_o  = mkey_q[rd_i.idx];
      rd_frac_o = mfrac_q[rd_i.idx];
    end else begin
      rd_key_o  = dkey_q[rd_i.idx];
      rd_frac_o = dfrac_q[rd_i.idx];
    end
  end

endmodule

>>> design/tsbi_core.sv
module tsbi_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsbi_pkg::cfg_t               cfg_i,
  tsbi_in_if.sink                      in_i,
  tsbi_out_if.source                   out_o,
  output tsbi_pkg::tbl_wr_t            wr_o,
  output tsbi_pkg::tbl_rd_t            rd_o,
  input  logic [tsbi_pkg::KeyW-1:0]    rd_key_i,
  input  logic [tsbi_pkg::FracW-1:0]   rd_frac_i
);

  tsbi_pkg::state_e   state_q, state_d;
  tsbi_pkg::tbl_sel_e stage_q;
  logic               ok_q;
  logic               out_valid_q;

  logic [tsbi_pkg::IdxW-1:0]    idx_q;
  logic [tsbi_pkg::CntW-1:0]    n_q;
  logic [tsbi_pkg::KeyW-1:0]    x_q;
  logic [tsbi_pkg::KeyW-1:0]    prev_k_q;
  logic [tsbi_pkg::FracW-1:0]   prev_f_q;
  logic [tsbi_pkg::FracW-1:0]   cur_f_q;
  logic [tsbi_pkg::KeyW-1:0]    span_q;
  logic [tsbi_pkg::RemW-1:0]    rem_q;
  logic [tsbi_pkg::FracW-1:0]   quo_q;
  logic [tsbi_pkg::DivCntW-1:0] cnt_q;
  logic [tsbi_pkg::ProdW-1:0]   prod_q;
  logic [tsbi_pkg::FracW-1:0]   val_q;
  logic [tsbi_pkg::KeyW-1:0]    live_q;
  logic [tsbi_pkg::FracW-1:0]   out_rate_q;
  logic [tsbi_pkg::KeyW-1:0]    out_live_q;
  tsbi_pkg::status_e            out_status_q;

  logic                         in_ready;
  logic                         in_fire;
  logic                         query_fire;
  logic                         out_load;
  logic                         mort_empty;
  logic                         in_seg;
  logic                         scan_end;
  logic [tsbi_pkg::KeyW-1:0]    span_w;
  logic [tsbi_pkg::KeyW-1:0]    diff_w;
  logic                         div_ge;
  logic [tsbi_pkg::RemW-1:0]    rem_sub;
  logic                         f_up;
  logic [tsbi_pkg::FracW-1:0]   f_diff;
  logic [tsbi_pkg::KeyW-1:0]    mul_a;
  logic [tsbi_pkg::FracW-1:0]   mul_b;
  logic [tsbi_pkg::ProdW-1:0]   prod_w;
  logic [tsbi_pkg::FracW-1:0]   d_w;
  logic [tsbi_pkg::RemW-1:0]    live_w;
  logic [tsbi_pkg::KeyW-1:0]    live_sat;

  assign in_fire    = in_i.valid && in_ready;
  assign query_fire = in_fire && (in_i.func == tsbi_pkg::FUNC_QUERY);
  assign mort_empty = (cfg_i.mort_n == '0);

  // shared compare/subtract
  assign in_seg   = (x_q >= prev_k_q) && (x_q <= rd_key_i);
  assign scan_end = ({1'b0, idx_q} == (n_q - tsbi_pkg::CntW'(1)));
  assign span_w   = rd_key_i - prev_k_q;
  assign diff_w   = x_q - prev_k_q;

  // restoring divider step
  assign div_ge  = (rem_q >= {1'b0, span_q});
  assign rem_sub = div_ge ? (rem_q - {1'b0, span_q}) : rem_q;

  // shared multiplier
  assign f_up   = (cur_f_q >= prev_f_q);
  assign f_diff = f_up ? (cur_f_q - prev_f_q) : (prev_f_q - cur_f_q);

  always_comb begin
    if (state_q == tsbi_pkg::S_LIVE) begin
      mul_a = cfg_i.initial_spores;
      mul_b = val_q;
    end else begin
      mul_a = tsbi_pkg::KeyW'(quo_q);
      mul_b = f_diff;
    end
  end

  assign prod_w   = tsbi_pkg::ProdW'(mul_a) * tsbi_pkg::ProdW'(mul_b);
  assign d_w      = tsbi_pkg::FracW'(prod_q >> tsbi_pkg::FracBits);
  assign live_w   = tsbi_pkg::RemW'(prod_q >> tsbi_pkg::FracBits);
  assign live_sat = live_w[tsbi_pkg::RemW-1] ? '1 : live_w[tsbi_pkg::KeyW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsbi_pkg::S_IDLE:  if (query_fire) state_d = tsbi_pkg::S_LAST;
      tsbi_pkg::S_LAST:  state_d = (x_q >= rd_key_i) ? tsbi_pkg::S_NEXT : tsbi_pkg::S_FIRST;
      tsbi_pkg::S_FIRST: state_d = (x_q <= rd_key_i) ? tsbi_pkg::S_NEXT : tsbi_pkg::S_SCAN;
      tsbi_pkg::S_SCAN: begin
        if (in_seg) begin
          state_d = (span_w == '0) ? tsbi_pkg::S_NEXT : tsbi_pkg::S_DIV;
        end else if (scan_end) begin
          state_d = tsbi_pkg::S_NEXT;
        end
      end
      tsbi_pkg::S_DIV: begin
        if (cnt_q == tsbi_pkg::DivCntW'(tsbi_pkg::FracBits)) state_d = tsbi_pkg::S_MUL;
      end
      tsbi_pkg::S_MUL:   state_d = tsbi_pkg::S_ADJ;
      tsbi_pkg::S_ADJ:   state_d = tsbi_pkg::S_NEXT;
      tsbi_pkg::S_NEXT: begin
        state_d = (stage_q == tsbi_pkg::TBL_DECAY) ? tsbi_pkg::S_LIVE : tsbi_pkg::S_DONE;
      end
      tsbi_pkg::S_LIVE:  state_d = tsbi_pkg::S_SAT;
      tsbi_pkg::S_SAT:   state_d = mort_empty ? tsbi_pkg::S_DONE : tsbi_pkg::S_LAST;
      tsbi_pkg::S_DONE:  if (out_load) state_d = tsbi_pkg::S_IDLE;
      default:           state_d = tsbi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_q == tsbi_pkg::S_IDLE);
    out_load  = (state_q == tsbi_pkg::S_DONE) && (!out_valid_q || out_o.ready);
    wr_o.en   = in_fire && ((in_i.func == tsbi_pkg::FUNC_WR_DECAY) ||
                            (in_i.func == tsbi_pkg::FUNC_WR_MORT));
    wr_o.sel  = (in_i.func == tsbi_pkg::FUNC_WR_MORT) ? tsbi_pkg::TBL_MORT
                                                      : tsbi_pkg::TBL_DECAY;
    wr_o.idx  = in_i.point_index;
    wr_o.key  = in_i.point_key;
    wr_o.frac = in_i.point_fraction;
    rd_o.sel  = stage_q;
    rd_o.idx  = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsbi_pkg::S_IDLE;
      stage_q     <= tsbi_pkg::TBL_DECAY;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (query_fire) begin
        stage_q <= tsbi_pkg::TBL_DECAY;
        ok_q    <= 1'b1;
      end
      if (state_q == tsbi_pkg::S_SAT) stage_q <= tsbi_pkg::TBL_MORT;
      if (state_q == tsbi_pkg::S_SCAN && !in_seg && scan_end) ok_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tsbi_pkg::S_IDLE: begin
        if (query_fire) begin
          x_q   <= tsbi_pkg::KeyW'(in_i.day);
          n_q   <= cfg_i.decay_n;
          idx_q <= tsbi_pkg::IdxW'(cfg_i.decay_n - tsbi_pkg::CntW'(1));
        end
      end
      tsbi_pkg::S_LAST: begin
        if (x_q >= rd_key_i) begin
          val_q <= rd_frac_i;
        end else begin
          idx_q <= '0;
        end
      end
      tsbi_pkg::S_FIRST: begin
        if (x_q <= rd_key_i) begin
          val_q <= rd_frac_i;
        end else begin
          prev_k_q <= rd_key_i;
          prev_f_q <= rd_frac_i;
          idx_q    <= tsbi_pkg::IdxW'(1);
        end
      end
      tsbi_pkg::S_SCAN: begin
        if (in_seg) begin
          span_q  <= span_w;
          val_q   <= prev_f_q;
          rem_q   <= tsbi_pkg::RemW'(diff_w);
          cur_f_q <= rd_frac_i;
          cnt_q   <= '0;
        end else if (scan_end) begin
          val_q <= '0;
        end else begin
          prev_k_q <= rd_key_i;
          prev_f_q <= rd_frac_i;
          idx_q    <= idx_q + tsbi_pkg::IdxW'(1);
        end
      end
      tsbi_pkg::S_DIV: begin
        rem_q <= {rem_sub[tsbi_pkg::RemW-2:0], 1'b0};
        quo_q <= {quo_q[tsbi_pkg::FracW-2:0], div_ge};
        cnt_q <= cnt_q + tsbi_pkg::DivCntW'(1);
      end
      tsbi_pkg::S_MUL:  prod_q <= prod_w;
      tsbi_pkg::S_ADJ:  val_q  <= f_up ? (prev_f_q + d_w) : (prev_f_q - d_w);
      tsbi_pkg::S_LIVE: prod_q <= prod_w;
      tsbi_pkg::S_SAT: begin
        live_q <= live_sat;
        x_q    <= live_sat;
        n_q    <= cfg_i.mort_n;
        idx_q  <= tsbi_pkg::IdxW'(cfg_i.mort_n - tsbi_pkg::CntW'(1));
        if (mort_empty) val_q <= '0;
      end
      tsbi_pkg::S_DONE: begin
        if (out_load) begin
          out_rate_q <= val_q;
          out_live_q <= live_q;
          if (mort_empty) begin
            out_status_q <= tsbi_pkg::STATUS_EMPTY;
          end else if (ok_q) begin
            out_status_q <= tsbi_pkg::STATUS_OK;
          end else begin
            out_status_q <= tsbi_pkg::STATUS_MISS;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.mortality_rate = out_rate_q;
  assign out_o.live_spores    = out_live_q;
  assign out_o.status         = out_status_q;

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsbi_pkg::S_MUL |-> quo_q <= tsbi_pkg::One)
    else $error("segment ratio above 1.0");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsbi_pkg::S_SCAN |-> idx_q != '0 && {1'b0, idx_q} < n_q)
    else $error("scan index out of range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsbi_pkg::S_DIV |-> span_q != '0 && rem_q < {span_q, 1'b0})
    else $error("divider remainder out of range");

  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsbi_pkg::S_NEXT |-> val_q <= tsbi_pkg::One)
    else $error("interpolated fraction above 1.0");

endmodule

>>> bench/tb_two_stage_breakpoint_interpolator_top.sv
`timescale 1ns / 100ps

module tb_two_stage_breakpoint_interpolator_top;

  localparam int WatchdogLimit = 5000;
  localparam int QuietCycles   = 100;
  localparam int HoldCycles    = 600;
  localparam int PhaseItems    = 350;
  localparam logic [tsbi_pkg::FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [tsbi_pkg::KeyW-1:0]  KeyMax      = {tsbi_pkg::KeyW{1'b1}};

  typedef struct packed {
    logic [tsbi_pkg::FuncW-1:0] func;
    logic [tsbi_pkg::DayW-1:0]  day;
    logic [tsbi_pkg::IdxW-1:0]  idx;
    logic [tsbi_pkg::KeyW-1:0]  key;
    logic [tsbi_pkg::FracW-1:0] frac;
  } item_t;

  typedef struct packed {
    logic [tsbi_pkg::FracW-1:0]   rate;
    logic [tsbi_pkg::KeyW-1:0]    live;
    logic [tsbi_pkg::StatusW-1:0] status;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  tsbi_pkg::cfg_reg_e cfg_idx;
  logic [tsbi_pkg::CfgDataW-1:0] cfg_data;

  tsbi_in_if  in_if ();
  tsbi_out_if out_if ();

  two_stage_breakpoint_interpolator_top dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // shadow copy of the block's tables and registers
  logic [tsbi_pkg::KeyW-1:0]  curve_key  [2][tsbi_pkg::TablePoints];
  logic [tsbi_pkg::FracW-1:0] curve_frac [2][tsbi_pkg::TablePoints];
  logic [tsbi_pkg::KeyW-1:0]  spores_cfg;
  logic [tsbi_pkg::CntW-1:0]  decay_cnt;
  logic [tsbi_pkg::CntW-1:0]  mort_cnt;

  result_t pending_results [$];
  result_t exp_res;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int out_hold      = 0;
  int errors        = 0;
  int n_items       = 0;
  int n_queries     = 0;
  int n_writes      = 0;
  int n_ignored     = 0;
  int n_results     = 0;
  int n_ok          = 0;
  int n_empty       = 0;
  int n_miss        = 0;
  int stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [tsbi_pkg::FracW-1:0] interp_point(
      input tsbi_pkg::tbl_sel_e sel, input int n,
      input logic [tsbi_pkg::KeyW-1:0] x, output bit hit);
    longint unsigned kl, kh, fl, fh, r;
    hit = 1'b1;
    if (x >= curve_key[sel][n-1]) return curve_frac[sel][n-1];
    if (x <= curve_key[sel][0]) return curve_frac[sel][0];
    for (int i = 0; i + 1 < n; i++) begin
      kl = curve_key[sel][i];
      kh = curve_key[sel][i+1];
      fl = curve_frac[sel][i];
      fh = curve_frac[sel][i+1];
      if (x >= kl && x <= kh) begin
        if (kh == kl) return tsbi_pkg::FracW'(fl);
        r = ((x - kl) << tsbi_pkg::FracBits) / (kh - kl);
        if (fh >= fl)
          return tsbi_pkg::FracW'(fl + ((r * (fh - fl)) >> tsbi_pkg::FracBits));
        return tsbi_pkg::FracW'(fl - ((r * (fl - fh)) >> tsbi_pkg::FracBits));
      end
    end
    hit = 1'b0;
    return '0;
  endfunction

  function automatic result_t predict_query(input logic [tsbi_pkg::DayW-1:0] day_v);
    int nd, nm;
    bit hit_d, hit_m;
    logic [tsbi_pkg::FracW-1:0] surv;
    longint unsigned live;
    result_t res;
    nd = (decay_cnt > tsbi_pkg::TablePoints) ? tsbi_pkg::TablePoints : int'(decay_cnt);
    if (nd == 0) nd = 1;
    surv = interp_point(tsbi_pkg::TBL_DECAY, nd, tsbi_pkg::KeyW'(day_v), hit_d);
    live = (longint'(spores_cfg) * longint'(surv)) >> tsbi_pkg::FracBits;
    if (live > KeyMax) live = KeyMax;
    res.live = tsbi_pkg::KeyW'(live);
    res.rate = '0;
    nm = (mort_cnt > tsbi_pkg::TablePoints) ? tsbi_pkg::TablePoints : int'(mort_cnt);
    if (nm == 0) begin
      res.status = tsbi_pkg::STATUS_EMPTY;
    end else begin
      res.rate = interp_point(tsbi_pkg::TBL_MORT, nm, res.live, hit_m);
      res.status = (hit_d && hit_m) ? tsbi_pkg::STATUS_OK : tsbi_pkg::STATUS_MISS;
    end
    return res;
  endfunction

  function automatic item_t make_item(input logic [tsbi_pkg::FuncW-1:0] func,
                                      input logic [tsbi_pkg::DayW-1:0] d,
                                      input logic [tsbi_pkg::IdxW-1:0] idx,
                                      input logic [tsbi_pkg::KeyW-1:0] key,
                                      input logic [tsbi_pkg::FracW-1:0] frac);
    item_t it;
    it.func = func;
    it.day  = d;
    it.idx  = idx;
    it.key  = key;
    it.frac = frac;
    return it;
  endfunction

  function automatic logic [tsbi_pkg::CfgDataW-1:0] pick_count();
    case ($urandom_range(7))
      0: return '0;
      1: return tsbi_pkg::CfgDataW'(1);
      2: return tsbi_pkg::CfgDataW'(tsbi_pkg::TablePoints);
      3: return tsbi_pkg::CfgDataW'(tsbi_pkg::TablePoints + 1);
      4: return tsbi_pkg::CfgDataW'((1 << tsbi_pkg::CntW) - 1);
      default: return tsbi_pkg::CfgDataW'($urandom_range(2, tsbi_pkg::TablePoints));
    endcase
  endfunction

  // model update on every accepted transfer and register write
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_idx)
        tsbi_pkg::CFG_INITIAL_SPORES:   spores_cfg = cfg_data[tsbi_pkg::KeyW-1:0];
        tsbi_pkg::CFG_DECAY_POINTS:     decay_cnt  = cfg_data[tsbi_pkg::CntW-1:0];
        tsbi_pkg::CFG_MORTALITY_POINTS: mort_cnt   = cfg_data[tsbi_pkg::CntW-1:0];
        default: ;
      endcase
    end
    if (in_if.valid && in_if.ready) begin
      case (in_if.func) inside
        tsbi_pkg::FUNC_QUERY: begin
          pending_results.push_back(predict_query(in_if.day));
          n_queries++;
          n_items++;
        end
        tsbi_pkg::FUNC_WR_DECAY, tsbi_pkg::FUNC_WR_MORT: begin
          curve_key[(in_if.func == tsbi_pkg::FUNC_WR_DECAY) ? tsbi_pkg::TBL_DECAY
                                                            : tsbi_pkg::TBL_MORT]
                   [in_if.point_index] = in_if.point_key;
          curve_frac[(in_if.func == tsbi_pkg::FUNC_WR_DECAY) ? tsbi_pkg::TBL_DECAY
                                                             : tsbi_pkg::TBL_MORT]
                    [in_if.point_index] =
            (in_if.point_fraction > tsbi_pkg::One) ? tsbi_pkg::One : in_if.point_fraction;
          n_writes++;
          n_items++;
        end
        default: n_ignored++;
      endcase
    end
  end

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: rate %0d live %0d status %0d",
                   out_if.mortality_rate, out_if.live_spores, out_if.status);
      end else begin
        exp_res = pending_results.pop_front();
        case (exp_res.status)
          tsbi_pkg::STATUS_OK:    n_ok++;
          tsbi_pkg::STATUS_EMPTY: n_empty++;
          default:                n_miss++;
        endcase
        if (out_if.mortality_rate !== exp_res.rate || out_if.live_spores !== exp_res.live ||
            out_if.status !== exp_res.status) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected rate %0d live %0d status %0d, got %0d %0d %0d",
                     n_results, exp_res.rate, exp_res.live, exp_res.status,
                     out_if.mortality_rate, out_if.live_spores, out_if.status);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_if.ready <= 1'b0;
      out_hold--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("[two_stage_breakpoint_interpolator_top] ERROR");
      $finish;
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.func           <= it.func;
    in_if.day            <= it.day;
    in_if.point_index    <= it.idx;
    in_if.point_key      <= it.key;
    in_if.point_fraction <= it.frac;
    in_if.valid          <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_quiescent();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic write_reg(input tsbi_pkg::cfg_reg_e r,
                           input logic [tsbi_pkg::CfgDataW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ascending keys with random steps, zero steps give repeated keys
  task automatic load_curve(input tsbi_pkg::tbl_sel_e sel, input int unsigned span);
    int unsigned step, acc;
    step = span / (tsbi_pkg::TablePoints - 1);
    acc  = $urandom_range(0, step);
    for (int i = 0; i < tsbi_pkg::TablePoints; i++) begin
      send_item(make_item((sel == tsbi_pkg::TBL_DECAY) ? tsbi_pkg::FUNC_WR_DECAY
                                                       : tsbi_pkg::FUNC_WR_MORT,
                          tsbi_pkg::DayW'($urandom), tsbi_pkg::IdxW'(i),
                          (acc > KeyMax) ? KeyMax : tsbi_pkg::KeyW'(acc),
                          ($urandom_range(15) == 0)
                            ? tsbi_pkg::FracW'($urandom)
                            : tsbi_pkg::FracW'($urandom_range(0, tsbi_pkg::One))));
      acc += $urandom_range(0, step);
    end
  endtask

  task automatic test_reset_curve();
    send_item(make_item(tsbi_pkg::FUNC_QUERY, '0, '0, '0, '0));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, '1, '0, '0, '0));
    wait_quiescent();
    write_reg(tsbi_pkg::CFG_INITIAL_SPORES, KeyMax);
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd2, '0, '0, '0));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd42, '0, '0, '0));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd20000, '0, '0, '0));
  endtask

  task automatic test_point_writes();
    send_item(make_item(tsbi_pkg::FUNC_WR_MORT, '0, 4'd0, 24'h000000, 17'h00000));
    send_item(make_item(tsbi_pkg::FUNC_WR_MORT, '0, 4'd1, 24'h100000, 17'h1FFFF));
    send_item(make_item(tsbi_pkg::FUNC_WR_MORT, '0, 4'd2, 24'h100000, 17'h08000));
    send_item(make_item(tsbi_pkg::FUNC_WR_MORT, '0, 4'd3, KeyMax, tsbi_pkg::One));
    send_item(make_item(FUNC_UNUSED, '1, '1, '1, '1));
    send_item(make_item(tsbi_pkg::FUNC_WR_DECAY, '0, 4'd15, KeyMax, 17'h1FFFF));
    wait_quiescent();
    write_reg(tsbi_pkg::CFG_MORTALITY_POINTS, tsbi_pkg::CfgDataW'(4));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd0, '0, '0, '0));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd2, '0, '0, '0));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd3, '0, '0, '0));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd1000, '0, '0, '0));
    wait_quiescent();
    write_reg(tsbi_pkg::CFG_DECAY_POINTS, tsbi_pkg::CfgDataW'(tsbi_pkg::TablePoints));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd7, '0, '0, '0));
    wait_quiescent();
    write_reg(tsbi_pkg::CFG_DECAY_POINTS, '0);
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd500, '0, '0, '0));
    wait_quiescent();
    write_reg(tsbi_pkg::CFG_DECAY_POINTS, tsbi_pkg::CfgDataW'((1 << tsbi_pkg::CntW) - 1));
    write_reg(tsbi_pkg::CFG_MORTALITY_POINTS,
              tsbi_pkg::CfgDataW'((1 << tsbi_pkg::CntW) - 1));
    send_item(make_item(tsbi_pkg::FUNC_QUERY, 16'd9, '0, '0, '0));
  endtask

  task automatic random_round();
    int nq, pick, nd;
    logic [tsbi_pkg::KeyW-1:0] spores_pick;
    logic [tsbi_pkg::KeyW-1:0] dlast;
    wait_quiescent();
    case ($urandom_range(7)) inside
      0:       spores_pick = '0;
      1:       spores_pick = KeyMax;
      2, 3:    spores_pick = tsbi_pkg::KeyW'($urandom_range(1, 4095));
      default: spores_pick = tsbi_pkg::KeyW'($urandom);
    endcase
    write_reg(tsbi_pkg::CFG_INITIAL_SPORES, spores_pick);
    write_reg(tsbi_pkg::CFG_DECAY_POINTS, pick_count());
    write_reg(tsbi_pkg::CFG_MORTALITY_POINTS, pick_count());
    if ($urandom_range(1) == 1) begin
      case ($urandom_range(3))
        0: load_curve(tsbi_pkg::TBL_DECAY, 60);
        1: load_curve(tsbi_pkg::TBL_DECAY, 2000);
        2: load_curve(tsbi_pkg::TBL_DECAY, 65535);
        default: load_curve(tsbi_pkg::TBL_DECAY, KeyMax);
      endcase
    end
    if ($urandom_range(3) != 0)
      load_curve(tsbi_pkg::TBL_MORT,
                 (spores_cfg == 0) ? $urandom_range(1, KeyMax) : spores_cfg);
    nd = (decay_cnt > tsbi_pkg::TablePoints) ? tsbi_pkg::TablePoints : int'(decay_cnt);
    if (nd == 0) nd = 1;
    dlast = curve_key[tsbi_pkg::TBL_DECAY][nd-1];
    nq = $urandom_range(15, 45);
    repeat (nq) begin
      pick = $urandom_range(99);
      if (pick < 6)
        send_item(make_item(($urandom_range(1) == 1) ? tsbi_pkg::FUNC_WR_DECAY
                                                     : tsbi_pkg::FUNC_WR_MORT,
                            tsbi_pkg::DayW'($urandom), tsbi_pkg::IdxW'($urandom),
                            tsbi_pkg::KeyW'($urandom), tsbi_pkg::FracW'($urandom)));
      else if (pick < 9)
        send_item(make_item(FUNC_UNUSED, tsbi_pkg::DayW'($urandom),
                            tsbi_pkg::IdxW'($urandom), tsbi_pkg::KeyW'($urandom),
                            tsbi_pkg::FracW'($urandom)));
      else if (pick < 75)
        send_item(make_item(tsbi_pkg::FUNC_QUERY,
                            tsbi_pkg::DayW'($urandom_range(0, (dlast > 65533) ? 65535
                                                                              : dlast + 2)),
                            tsbi_pkg::IdxW'($urandom), tsbi_pkg::KeyW'($urandom),
                            tsbi_pkg::FracW'($urandom)));
      else
        send_item(make_item(tsbi_pkg::FUNC_QUERY, tsbi_pkg::DayW'($urandom),
                            tsbi_pkg::IdxW'($urandom), tsbi_pkg::KeyW'($urandom),
                            tsbi_pkg::FracW'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 64; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 64; end
        default: begin in_idle_pct = 17; out_stall_pct = 17; end
      endcase
      target = n_items + PhaseItems;
      while (n_items < target) random_round();
    end
  endtask

  // output held off while queries keep coming, so the input must stall
  task automatic test_output_holdoff();
    wait_quiescent();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    out_hold      = HoldCycles;
    repeat (14)
      send_item(make_item(tsbi_pkg::FUNC_QUERY, tsbi_pkg::DayW'($urandom_range(0, 50)),
                          '0, '0, '0));
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = tsbi_pkg::CFG_INITIAL_SPORES;
    cfg_data             = '0;
    in_if.valid          = 1'b0;
    in_if.func           = tsbi_pkg::FUNC_QUERY;
    in_if.day            = '0;
    in_if.point_index    = '0;
    in_if.point_key      = '0;
    in_if.point_fraction = '0;
    out_if.ready         = 1'b0;
    for (int i = 0; i < tsbi_pkg::TablePoints; i++) begin
      curve_key[tsbi_pkg::TBL_DECAY][i]  = '0;
      curve_frac[tsbi_pkg::TBL_DECAY][i] = '0;
      curve_key[tsbi_pkg::TBL_MORT][i]   = '0;
      curve_frac[tsbi_pkg::TBL_MORT][i]  = '0;
    end
    // default decay curve; fractions in thousandths, rounded to nearest
    curve_key[tsbi_pkg::TBL_DECAY][0] = tsbi_pkg::KeyW'(1);
    curve_key[tsbi_pkg::TBL_DECAY][1] = tsbi_pkg::KeyW'(3);
    curve_key[tsbi_pkg::TBL_DECAY][2] = tsbi_pkg::KeyW'(6);
    curve_key[tsbi_pkg::TBL_DECAY][3] = tsbi_pkg::KeyW'(13);
    curve_key[tsbi_pkg::TBL_DECAY][4] = tsbi_pkg::KeyW'(20);
    curve_key[tsbi_pkg::TBL_DECAY][5] = tsbi_pkg::KeyW'(42);
    curve_frac[tsbi_pkg::TBL_DECAY][0] =
      tsbi_pkg::FracW'(((1000 << tsbi_pkg::FracBits) + 500) / 1000);
    curve_frac[tsbi_pkg::TBL_DECAY][1] =
      tsbi_pkg::FracW'(((160 << tsbi_pkg::FracBits) + 500) / 1000);
    curve_frac[tsbi_pkg::TBL_DECAY][2] =
      tsbi_pkg::FracW'(((260 << tsbi_pkg::FracBits) + 500) / 1000);
    curve_frac[tsbi_pkg::TBL_DECAY][3] =
      tsbi_pkg::FracW'(((130 << tsbi_pkg::FracBits) + 500) / 1000);
    curve_frac[tsbi_pkg::TBL_DECAY][4] =
      tsbi_pkg::FracW'(((10 << tsbi_pkg::FracBits) + 500) / 1000);
    curve_frac[tsbi_pkg::TBL_DECAY][5] =
      tsbi_pkg::FracW'(((3 << tsbi_pkg::FracBits) + 500) / 1000);
    spores_cfg = '0;
    decay_cnt  = tsbi_pkg::CntW'(6);
    mort_cnt   = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_curve();
    test_point_writes();
    test_random_traffic();
    test_output_holdoff();
    wait_quiescent();

    errors += pending_results.size();
    $display("covered %0d queries (%0d ok, %0d empty mortality table, %0d unmatched), %0d writes",
             n_queries, n_ok, n_empty, n_miss, n_writes);
    $display("%0d results checked, %0d ignored items, %0d mismatches, four idle mixes + hold-off",
             n_results, n_ignored, errors);
    if (errors == 0) begin
      $display("[two_stage_breakpoint_interpolator_top] OK");
    end else begin
      $display("[two_stage_breakpoint_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule

>>> two_stage_breakpoint_interpolator_top.f
design/tsbi_pkg.sv
design/tsbi_in_if.sv
design/tsbi_out_if.sv
design/tsbi_tables.sv
design/tsbi_core.sv
design/two_stage_breakpoint_interpolator_top.sv
bench/tb_two_stage_breakpoint_interpolator_top.sv
